### hdl/private_allelic_richness_rarefaction_assert.svh
// Assertion macros for the private allelic richness block.
// Clock clk and reset rst are taken from the scope of the use.
`ifndef PRIVATE_ALLELIC_RICHNESS_RAREFACTION_ASSERT_SVH
`define PRIVATE_ALLELIC_RICHNESS_RAREFACTION_ASSERT_SVH
`ifndef SYNTHESIS
// checked property, quiet while rst is high
`define PARR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked property, also during reset
`define PARR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PARR_ASSERT(lbl, prop, msg)
`define PARR_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

### hdl/parr_pkg.sv
// Shared constants, types and fixed-point helpers of the rarefaction block.
// No dependencies; used by the channel interfaces and the top level.
`default_nettype none
package parr_pkg;

  // sizing
  localparam int MAX_GROUPS       = 16;
  localparam int MAX_ALLELE_SLOTS = 64;
  localparam int MAX_SAMPLE_G     = 64;
  localparam int COUNT_BITS       = 16;

  // field widths
  localparam int GROUPING_W = 4;
  localparam int ALLELE_W   = 6;
  localparam int SIZE_G_W   = 7;
  localparam int RICH_W     = 32;
  localparam int NG_W       = 5;
  localparam int NA_W       = 7;
  localparam int GL_W       = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  // derived storage geometry
  localparam int GIDX_W    = $clog2(MAX_GROUPS);
  localparam int AIDX_W    = $clog2(MAX_ALLELE_SLOTS);
  localparam int GC_W      = $clog2(MAX_SAMPLE_G + 1);
  localparam int G_STRIDE  = MAX_SAMPLE_G + 1;
  localparam int CNT_DEPTH = MAX_GROUPS * MAX_ALLELE_SLOTS;
  localparam int ROW_W     = $clog2(CNT_DEPTH);
  localparam int TAB_DEPTH = CNT_DEPTH * G_STRIDE;
  localparam int TAB_AW    = $clog2(TAB_DEPTH);

  // UQ1.32 absence probability
  localparam int Q_W = 33;
  localparam logic [Q_W-1:0] Q_ONE = {1'b1, {(Q_W-1){1'b0}}};

  // divider and accumulator
  localparam int DVD_W  = Q_W + COUNT_BITS;
  localparam int DIV_CW = $clog2(DVD_W);
  localparam int ACC_W  = Q_W + $clog2(MAX_ALLELE_SLOTS + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_GROUPINGS = 2'd0,
    CFG_NUM_ALLELES   = 2'd1,
    CFG_G_LIMIT       = 2'd2
  } cfg_reg_t;

  typedef enum logic [0:0] {
    MODE_LOAD  = 1'b0,
    MODE_QUERY = 1'b1
  } mode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_B_ROW,
    S_B_INIT,
    S_B_STEP,
    S_B_DIV,
    S_Q_RUN,
    S_Q_DRAIN,
    S_Q_DONE
  } state_t;

  // row of the count store / absence table for grouping p, allele i
  function automatic logic [ROW_W-1:0] row_of(input logic [GIDX_W-1:0] p,
                                               input logic [AIDX_W-1:0] i);
    row_of = ROW_W'(ROW_W'(p) * ROW_W'(MAX_ALLELE_SLOTS)) + ROW_W'(i);
  endfunction

  function automatic logic [TAB_AW-1:0] tab_addr(input logic [ROW_W-1:0] row,
                                                 input logic [GC_W-1:0] g);
    tab_addr = TAB_AW'(TAB_AW'(row) * TAB_AW'(G_STRIDE)) + TAB_AW'(g);
  endfunction

  // floor(a*b / 2^32) for a, b <= 1.0
  function automatic logic [Q_W-1:0] qmul(input logic [Q_W-1:0] a,
                                          input logic [Q_W-1:0] b);
    logic [2*(Q_W-1)-1:0] prod;
    prod = a[Q_W-2:0] * b[Q_W-2:0];
    if (a[Q_W-1])      qmul = b;
    else if (b[Q_W-1]) qmul = a;
    else               qmul = {1'b0, prod[2*(Q_W-1)-1:Q_W-1]};
  endfunction

endpackage
`default_nettype wire

### hdl/parr_if.sv
// Valid/ready channels of the rarefaction block: load/query items, results
// and configuration writes. Depends on parr_pkg.
`default_nettype none
interface parr_item_if import parr_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic                  mode;
  logic [GROUPING_W-1:0] grouping;
  logic [ALLELE_W-1:0]   allele;
  logic [COUNT_BITS-1:0] allele_count;
  logic [COUNT_BITS-1:0] sample_size;
  logic [SIZE_G_W-1:0]   size_g;
  logic                  last;
  modport source(output valid, mode, grouping, allele, allele_count, sample_size,
                 size_g, last, input ready);
  modport sink(input valid, mode, grouping, allele, allele_count, sample_size,
               size_g, last, output ready);
endinterface

interface parr_result_if import parr_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [GROUPING_W-1:0] out_grouping;
  logic [SIZE_G_W-1:0]   out_size_g;
  logic [RICH_W-1:0]     richness;
  logic                  undefined_flag;
  modport source(output valid, out_grouping, out_size_g, richness, undefined_flag,
                 input ready);
  modport sink(input valid, out_grouping, out_size_g, richness, undefined_flag,
               output ready);
endinterface

interface parr_cfg_if import parr_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

### hdl/private_allelic_richness_rarefaction.sv
// Top level of the private allelic richness rarefaction block.
// Depends on parr_pkg, parr_if.sv and the assertion macro header.

// Works on one locus at a time, one request at a time. A load request
// stores one allele count and the grouping's sample size. A load marked
// last starts a table build that holds off requests until it ends: each
// table entry up to the built limit takes a multiply step and then a
// bit-serial divider, entries past it a single write. A query reads the
// absence table one entry per cycle; an undefined or trivial query skips
// the table and goes straight to the result. The result sits in an output
// register, so the next request is taken while it waits. Configuration
// writes are always ready.
`default_nettype none
`include "private_allelic_richness_rarefaction_assert.svh"
module private_allelic_richness_rarefaction import parr_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  parr_cfg_if.sink      cfg,
  parr_item_if.sink     item,
  parr_result_if.source result
);

  // configuration registers
  logic [NG_W-1:0] num_groupings;
  logic [NA_W-1:0] num_alleles;
  logic [GL_W-1:0] g_limit;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_groupings <= NG_W'(1);
      num_alleles   <= NA_W'(1);
      g_limit       <= GL_W'(64);
    end else if (cfg.valid) begin
      unique case (cfg_reg_t'(cfg.index))
        CFG_NUM_GROUPINGS: num_groupings <= cfg.data[NG_W-1:0];
        CFG_NUM_ALLELES:   num_alleles   <= cfg.data[NA_W-1:0];
        CFG_G_LIMIT:       g_limit       <= cfg.data[GL_W-1:0];
        default: ;
      endcase
    end
  end

  // saturated counts
  logic [NG_W-1:0] eff_ng;
  logic [NA_W-1:0] eff_na;
  logic [GL_W-1:0] eff_lim;

  always_comb begin
    if (num_groupings == '0)                         eff_ng = NG_W'(1);
    else if (32'(num_groupings) > MAX_GROUPS)        eff_ng = NG_W'(MAX_GROUPS);
    else                                             eff_ng = num_groupings;
    if (32'(num_alleles) > MAX_ALLELE_SLOTS)         eff_na = NA_W'(MAX_ALLELE_SLOTS);
    else                                             eff_na = num_alleles;
    if (32'(g_limit) > MAX_SAMPLE_G)                 eff_lim = GL_W'(MAX_SAMPLE_G);
    else                                             eff_lim = g_limit;
  end

  // state and working registers
  state_t state, state_next;

  logic [GIDX_W-1:0]     cp;
  logic [AIDX_W-1:0]     ci;
  logic [GC_W-1:0]       bg;
  logic [COUNT_BITS-1:0] n_tot;
  logic [COUNT_BITS-1:0] n_al;
  logic [Q_W-1:0]        q;
  logic [DVD_W-1:0]      dvd;
  logic [COUNT_BITS-1:0] rem;
  logic [COUNT_BITS-1:0] den;
  logic [DIV_CW-1:0]     dcnt;
  logic [COUNT_BITS-1:0] smallest;

  logic [GROUPING_W-1:0] qgrp;
  logic [SIZE_G_W-1:0]   qg;
  logic [RICH_W-1:0]     res_rich;
  logic                  res_flag;

  // stores
  logic [COUNT_BITS-1:0] count_mem [CNT_DEPTH];
  logic [COUNT_BITS-1:0] size_reg  [MAX_GROUPS];
  logic [Q_W-1:0]        tab_mem   [TAB_DEPTH];
  logic [COUNT_BITS-1:0] count_rd;
  logic [Q_W-1:0]        tab_rd;

  logic                  item_acc;
  logic                  load_we;
  logic                  tab_we;
  logic [TAB_AW-1:0]     tab_waddr;
  logic [TAB_AW-1:0]     tab_raddr;
  logic [Q_W-1:0]        tab_wdata;
  logic [ROW_W-1:0]      row;

  assign item_acc = item.valid && item.ready;
  assign load_we  = item_acc && (mode_t'(item.mode) == MODE_LOAD);
  assign row      = row_of(cp, ci);

  // loop bounds
  logic last_p, last_i, last_g;
  assign last_p = (NG_W'(cp) + NG_W'(1)) >= eff_ng;
  assign last_i = (NA_W'(ci) + NA_W'(1)) >= eff_na;
  assign last_g = 32'(bg) >= MAX_SAMPLE_G;

  // recurrence step operands
  logic [COUNT_BITS-1:0] top;
  logic [GC_W-1:0]       gm1;
  logic [COUNT_BITS-1:0] den_c;
  logic [COUNT_BITS:0]   used;
  logic [COUNT_BITS-1:0] num_c;
  logic                  g_in;

  always_comb begin
    top   = (COUNT_BITS'(eff_lim) < n_tot) ? COUNT_BITS'(eff_lim) : n_tot;
    g_in  = COUNT_BITS'(bg) <= top;
    gm1   = bg - GC_W'(1);
    den_c = n_tot - COUNT_BITS'(gm1);
    used  = {1'b0, n_al} + (COUNT_BITS+1)'(gm1);
    num_c = (used >= {1'b0, n_tot}) ? '0 : COUNT_BITS'({1'b0, n_tot} - used);
  end

  // one restoring divider step
  logic [COUNT_BITS:0]   shifted;
  logic                  qbit;
  logic [COUNT_BITS-1:0] rem_n;
  logic [DVD_W-1:0]      dvd_n;

  always_comb begin
    shifted = {rem, dvd[DVD_W-1]};
    qbit    = shifted >= {1'b0, den};
    rem_n   = qbit ? COUNT_BITS'(shifted - {1'b0, den}) : shifted[COUNT_BITS-1:0];
    dvd_n   = {dvd[DVD_W-2:0], qbit};
  end

  // query admission
  logic q_flag, q_zero;
  always_comb begin
    q_flag = (NG_W'(item.grouping) >= eff_ng) ||
             (GL_W'(item.size_g) > eff_lim) ||
             (COUNT_BITS'(item.size_g) > smallest);
    q_zero = (item.size_g == '0) || (eff_na == '0);
  end

  // query pipeline registers
  logic           s1_v, s1_own, s1_last, s1_end;
  logic           fin_v, fin_end;
  logic [Q_W-1:0] others, own_q, own_fin, prod_fin;
  logic           term_v, term_end;
  logic [Q_W-1:0] term;
  logic [ACC_W-1:0] acc, acc_sum;
  logic [ACC_W+RICH_W-1:0] acc_ext;
  logic [RICH_W-1:0] rich_sat;

  always_comb begin
    acc_sum  = acc + ACC_W'(term);
    acc_ext  = (ACC_W+RICH_W)'(acc_sum) >> 8;
    rich_sat = (|acc_ext[ACC_W+RICH_W-1:RICH_W]) ? '1 : acc_ext[RICH_W-1:0];
  end

  logic out_free;
  assign out_free = !result.valid || result.ready;

  // next state, ready and table write port
  always_comb begin
    state_next = state;
    item.ready = 1'b0;
    tab_we     = 1'b0;
    tab_wdata  = '0;
    tab_waddr  = tab_addr(row, bg);
    tab_raddr  = tab_addr(row, GC_W'(qg));
    unique case (state)
      S_IDLE: begin
        item.ready = 1'b1;
        if (item_acc) begin
          if (mode_t'(item.mode) == MODE_LOAD) begin
            if (item.last) state_next = S_B_ROW;
          end else if (q_flag || q_zero) begin
            state_next = S_Q_DONE;
          end else begin
            state_next = S_Q_RUN;
          end
        end
      end
      S_B_ROW: begin
        if (eff_na == '0) begin
          if (last_p) state_next = S_IDLE;
        end else begin
          state_next = S_B_INIT;
        end
      end
      S_B_INIT: begin
        tab_we     = 1'b1;
        tab_wdata  = Q_ONE;
        tab_waddr  = tab_addr(row, '0);
        state_next = S_B_STEP;
      end
      S_B_STEP: begin
        if (g_in) begin
          state_next = S_B_DIV;
        end else begin
          tab_we = 1'b1;
          if (last_g) state_next = (last_i && last_p) ? S_IDLE : S_B_ROW;
        end
      end
      S_B_DIV: begin
        if (dcnt == '0) begin
          tab_we    = 1'b1;
          tab_wdata = dvd_n[Q_W-1:0];
          if (last_g) state_next = (last_i && last_p) ? S_IDLE : S_B_ROW;
          else        state_next = S_B_STEP;
        end
      end
      S_Q_RUN: begin
        if (last_p && last_i) state_next = S_Q_DRAIN;
      end
      S_Q_DRAIN: begin
        if (term_v && term_end) state_next = S_Q_DONE;
      end
      S_Q_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // stores: load writes, build reads counts, query reads the table
  always_ff @(posedge clk) begin
    if (load_we && 32'(item.grouping) < MAX_GROUPS) begin
      size_reg[GIDX_W'(item.grouping)] <= item.sample_size;
      if (32'(item.allele) < MAX_ALLELE_SLOTS)
        count_mem[row_of(GIDX_W'(item.grouping), AIDX_W'(item.allele))] <=
          item.allele_count;
    end
    count_rd <= count_mem[row];
  end

  always_ff @(posedge clk) begin
    if (tab_we) tab_mem[tab_waddr] <= tab_wdata;
    tab_rd <= tab_mem[tab_raddr];
  end

  // sequencer datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      smallest <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (item_acc) begin
            cp       <= '0;
            ci       <= '0;
            qgrp     <= item.grouping;
            qg       <= item.size_g;
            others   <= Q_ONE;
            acc      <= '0;
            res_rich <= '0;
            res_flag <= q_flag;
          end
        end
        S_B_ROW: begin
          n_tot <= size_reg[cp];
          if (ci == '0) begin
            if (cp == '0 || size_reg[cp] < smallest) smallest <= size_reg[cp];
          end
          if (eff_na == '0 && !last_p) cp <= cp + GIDX_W'(1);
        end
        S_B_INIT: begin
          n_al <= count_rd;
          q    <= Q_ONE;
          bg   <= GC_W'(1);
        end
        S_B_STEP: begin
          if (g_in) begin
            dvd  <= DVD_W'(q * num_c);
            den  <= den_c;
            rem  <= '0;
            dcnt <= DIV_CW'(DVD_W - 1);
          end else begin
            bg <= bg + GC_W'(1);
            if (last_g) begin
              if (last_i) begin
                ci <= '0;
                cp <= cp + GIDX_W'(1);
              end else begin
                ci <= ci + AIDX_W'(1);
              end
            end
          end
        end
        S_B_DIV: begin
          dvd  <= dvd_n;
          rem  <= rem_n;
          dcnt <= dcnt - DIV_CW'(1);
          if (dcnt == '0) begin
            q  <= dvd_n[Q_W-1:0];
            bg <= bg + GC_W'(1);
            if (last_g) begin
              if (last_i) begin
                ci <= '0;
                cp <= cp + GIDX_W'(1);
              end else begin
                ci <= ci + AIDX_W'(1);
              end
            end
          end
        end
        S_Q_RUN: begin
          if (last_p) begin
            cp <= '0;
            ci <= ci + AIDX_W'(1);
          end else begin
            cp <= cp + GIDX_W'(1);
          end
        end
        S_Q_DRAIN: begin
          if (term_v && term_end) res_rich <= rich_sat;
        end
        default: ;
      endcase

      // accumulate finished terms
      if (term_v) acc <= acc_sum;

      // product stage: others' chain per allele
      if (s1_v) begin
        if (s1_last) begin
          own_fin  <= s1_own ? tab_rd : own_q;
          prod_fin <= s1_own ? others : qmul(others, tab_rd);
          others   <= Q_ONE;
        end else if (s1_own) begin
          own_q <= tab_rd;
        end else begin
          others <= qmul(others, tab_rd);
        end
      end

      // final term per allele
      term <= qmul(Q_ONE - own_fin, prod_fin);
    end
  end

  // pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v   <= 1'b0;
      fin_v  <= 1'b0;
      term_v <= 1'b0;
    end else begin
      s1_v     <= (state == S_Q_RUN);
      s1_own   <= (GROUPING_W'(cp) == qgrp);
      s1_last  <= last_p;
      s1_end   <= last_p && last_i;
      fin_v    <= s1_v && s1_last;
      fin_end  <= s1_end;
      term_v   <= fin_v;
      term_end <= fin_end;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (state == S_Q_DONE && out_free) begin
      result.valid          <= 1'b1;
      result.out_grouping   <= qgrp;
      result.out_size_g     <= qg;
      result.richness       <= res_rich;
      result.undefined_flag <= res_flag;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  `PARR_ASSERT(a_div_nonzero, (state == S_B_DIV) |-> (den != '0), "divider has zero divisor")
  `PARR_ASSERT(a_rem_bound, (state == S_B_DIV) |-> (rem < den), "divider remainder not below divisor")
  `PARR_ASSERT(a_q_bound, (state == S_B_DIV && dcnt == '0) |-> (dvd_n[DVD_W-1:Q_W] == '0 && dvd_n[Q_W-1:0] <= Q_ONE), "absence probability above one")
  `PARR_ASSERT(a_pipe_idle, (state == S_IDLE) |-> (!s1_v && !fin_v && !term_v), "query pipeline busy while idle")
  `PARR_ASSERT(a_hold_done, (state == S_Q_DONE && result.valid && !result.ready) |=> (state == S_Q_DONE), "result overwrote a pending output")

endmodule
`default_nettype wire

### tb/richness_checker.sv
// Checker for the private allelic richness block: mirrors the stores,
// rebuilds the absence table and predicts every query answer.
// Depends on parr_pkg and the channel interfaces in parr_if.sv.
`default_nettype none
module richness_checker import parr_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  parr_cfg_if    cfg,
  parr_item_if   item,
  parr_result_if result,
  output int     errors,
  output int     pending,
  output int     answers_checked,
  output int     builds_seen
);

  typedef struct packed {
    logic [GROUPING_W-1:0] grouping;
    logic [SIZE_G_W-1:0]   size_g;
    logic [RICH_W-1:0]     richness;
    logic                  undefined_flag;
  } answer_t;

  answer_t answers_due[$];

  // mirrored state
  logic [COUNT_BITS-1:0] count_mem[CNT_DEPTH];
  logic [COUNT_BITS-1:0] size_mem[MAX_GROUPS];
  logic [Q_W-1:0]        absence[TAB_DEPTH];
  logic [COUNT_BITS-1:0] smallest;
  logic [NG_W-1:0]       ng_reg;
  logic [NA_W-1:0]       na_reg;
  logic [GL_W-1:0]       gl_reg;

  function automatic int eff_groups();
    if (ng_reg < 1) return 1;
    if (ng_reg > MAX_GROUPS) return MAX_GROUPS;
    return int'(ng_reg);
  endfunction

  function automatic int eff_alleles();
    return (na_reg > MAX_ALLELE_SLOTS) ? MAX_ALLELE_SLOTS : int'(na_reg);
  endfunction

  function automatic int eff_limit();
    return (gl_reg > MAX_SAMPLE_G) ? MAX_SAMPLE_G : int'(gl_reg);
  endfunction

  // floor(a*b / 2^32) on UQ1.32
  function automatic logic [Q_W-1:0] absence_mul(logic [Q_W-1:0] a, logic [Q_W-1:0] b);
    logic [63:0] wide;
    if (a >= Q_ONE) return b;
    if (b >= Q_ONE) return a;
    wide = 64'(a) * 64'(b);
    return Q_W'(wide >> 32);
  endfunction

  // one recurrence step, truncated
  function automatic logic [Q_W-1:0] absence_step(logic [Q_W-1:0] q,
                                                  longint unsigned num,
                                                  longint unsigned den);
    logic [63:0] wide;
    wide = 64'(q) * num;
    return Q_W'(wide / den);
  endfunction

  function automatic void build_absence();
    int ngr;
    int nal;
    int lim;
    int top;
    int row;
    logic [Q_W-1:0] q;
    longint unsigned n_tot, n_al, den, used, num;
    ngr = eff_groups();
    nal = eff_alleles();
    lim = eff_limit();
    smallest = size_mem[0];
    for (int p = 1; p < ngr; p++)
      if (size_mem[p] < smallest) smallest = size_mem[p];
    for (int p = 0; p < ngr; p++) begin
      n_tot = size_mem[p];
      top = (lim < n_tot) ? lim : int'(n_tot);
      for (int i = 0; i < nal; i++) begin
        row = p * MAX_ALLELE_SLOTS + i;
        n_al = count_mem[row];
        q = Q_ONE;
        absence[row * G_STRIDE] = Q_ONE;
        for (int g = 1; g <= MAX_SAMPLE_G; g++) begin
          if (g <= top) begin
            den  = n_tot - (g - 1);
            used = n_al + (g - 1);
            num  = (used >= n_tot) ? 0 : n_tot - used;
            q = absence_step(q, num, den);
            absence[row * G_STRIDE + g] = q;
          end else begin
            absence[row * G_STRIDE + g] = '0;
          end
        end
      end
    end
  endfunction

  function automatic answer_t predict_richness(int grp, int g);
    answer_t ans;
    int ngr;
    int nal;
    logic [63:0] acc;
    logic [Q_W-1:0] others;
    ngr = eff_groups();
    nal = eff_alleles();
    ans.grouping = GROUPING_W'(grp);
    ans.size_g = SIZE_G_W'(g);
    ans.richness = '0;
    ans.undefined_flag = 1'b0;
    if (grp >= ngr || g > eff_limit() || g > smallest) begin
      ans.undefined_flag = 1'b1;
    end else begin
      acc = '0;
      for (int i = 0; i < nal; i++) begin
        others = Q_ONE;
        for (int p = 0; p < ngr; p++)
          if (p != grp)
            others = absence_mul(others, absence[(p * MAX_ALLELE_SLOTS + i) * G_STRIDE + g]);
        acc += absence_mul(Q_ONE - absence[(grp * MAX_ALLELE_SLOTS + i) * G_STRIDE + g],
                           others);
      end
      acc = acc >> 8;
      ans.richness = (acc > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : acc[31:0];
    end
    return ans;
  endfunction

  always @(posedge clk) begin
    answer_t exp_ans;
    if (rst) begin
      ng_reg = 1;
      na_reg = 1;
      gl_reg = 64;
      smallest = '0;
      answers_due.delete();
      errors = 0;
      answers_checked = 0;
      builds_seen = 0;
    end else begin
      // configuration writes
      if (cfg.valid && cfg.ready) begin
        case (cfg_reg_t'(cfg.index))
          CFG_NUM_GROUPINGS: ng_reg = NG_W'(cfg.data);
          CFG_NUM_ALLELES:   na_reg = NA_W'(cfg.data);
          CFG_G_LIMIT:       gl_reg = GL_W'(cfg.data);
          default: ;
        endcase
      end
      // answers against the oldest prediction
      if (result.valid && result.ready) begin
        if (answers_due.size() == 0) begin
          errors++;
          $display("%0t unexpected answer grp=%0d g=%0d rich=%h undef=%b", $time,
                   result.out_grouping, result.out_size_g, result.richness,
                   result.undefined_flag);
        end else begin
          exp_ans = answers_due.pop_front();
          answers_checked++;
          if (result.out_grouping !== exp_ans.grouping) begin
            errors++;
            $display("%0t out_grouping expected %0d got %0d", $time, exp_ans.grouping,
                     result.out_grouping);
          end
          if (result.out_size_g !== exp_ans.size_g) begin
            errors++;
            $display("%0t out_size_g expected %0d got %0d", $time, exp_ans.size_g,
                     result.out_size_g);
          end
          if (result.richness !== exp_ans.richness) begin
            errors++;
            $display("%0t richness expected %h got %h (grp %0d g %0d)", $time,
                     exp_ans.richness, result.richness, exp_ans.grouping, exp_ans.size_g);
          end
          if (result.undefined_flag !== exp_ans.undefined_flag) begin
            errors++;
            $display("%0t undefined_flag expected %b got %b (grp %0d g %0d)", $time,
                     exp_ans.undefined_flag, result.undefined_flag, exp_ans.grouping,
                     exp_ans.size_g);
          end
        end
      end
      // load and query requests
      if (item.valid && item.ready) begin
        if (mode_t'(item.mode) == MODE_LOAD) begin
          size_mem[item.grouping] = item.sample_size;
          count_mem[item.grouping * MAX_ALLELE_SLOTS + item.allele] = item.allele_count;
          if (item.last) begin
            build_absence();
            builds_seen++;
          end
        end else begin
          // queue the prediction behind the older ones
          answers_due = {answers_due,
                         predict_richness(int'(item.grouping), int'(item.size_g))};
        end
      end
    end
    pending = answers_due.size();
  end

endmodule
`default_nettype wire

### tb/tb.sv
// Testbench top for the private allelic richness block: clock, reset,
// request stimulus and verdict. Depends on parr_pkg, parr_if.sv and
// richness_checker.
`default_nettype none
module tb;
  import parr_pkg::*;

  logic clk;
  logic rst;
  int   errors, pending, answers_checked, builds_seen;
  int   requests_sent;
  int   burst_left;
  int   rx_tick;

  parr_cfg_if    cfg_ch();
  parr_item_if   item_ch();
  parr_result_if res_ch();

  private_allelic_richness_rarefaction u_top (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch),
    .item   (item_ch),
    .result (res_ch)
  );

  richness_checker u_check (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg_ch),
    .item            (item_ch),
    .result          (res_ch),
    .errors          (errors),
    .pending         (pending),
    .answers_checked (answers_checked),
    .builds_seen     (builds_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #500_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // result side stalls: always ready, coin flip, then mostly stalled
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      rx_tick <= 0;
    end else begin
      rx_tick <= rx_tick + 1;
      case ((rx_tick / 300) % 3)
        0:       res_ch.ready <= 1'b1;
        1:       res_ch.ready <= 1'($urandom_range(0, 1));
        default: res_ch.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // one request, sent in bursts with random gaps
  task automatic send_request(mode_t md, int grp, int al, int cnt, int sz, int g, bit lst);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 12);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        item_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    item_ch.valid        <= 1'b1;
    item_ch.mode         <= md;
    item_ch.grouping     <= GROUPING_W'(grp);
    item_ch.allele       <= ALLELE_W'(al);
    item_ch.allele_count <= COUNT_BITS'(cnt);
    item_ch.sample_size  <= COUNT_BITS'(sz);
    item_ch.size_g       <= SIZE_G_W'(g);
    item_ch.last         <= lst;
    do @(posedge clk); while (!item_ch.ready);
    burst_left--;
    requests_sent++;
  endtask

  task automatic query(int grp, int g);
    send_request(MODE_QUERY, grp, $urandom_range(0, 63), $urandom_range(0, 65535),
                 $urandom_range(0, 65535), g, 1'($urandom_range(0, 1)));
  endtask

  task automatic write_register(cfg_reg_t idx, int value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= CFG_DATA_W'(value);
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  // every answer back; phases end on a query, so the block is idle then
  task automatic wait_drained();
    item_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (3) @(posedge clk);
  endtask

  // one locus: settings, stray loads, full load, build, queries
  task automatic run_locus(int ng_val, int na_val, int gl_val, bit big);
    int eng, ena, egl, rows, sz, cnt, nq, grp, g, pick;
    eng = ng_val & 31;
    eng = (eng < 1) ? 1 : (eng > MAX_GROUPS) ? MAX_GROUPS : eng;
    ena = (na_val > MAX_ALLELE_SLOTS) ? MAX_ALLELE_SLOTS : na_val;
    egl = (gl_val > MAX_SAMPLE_G) ? MAX_SAMPLE_G : gl_val;
    rows = (ena < 1) ? 1 : ena;
    wait_drained();
    write_register(CFG_NUM_GROUPINGS, ng_val);
    write_register(CFG_NUM_ALLELES, na_val);
    write_register(CFG_G_LIMIT, gl_val);
    // stray loads; those in the loaded groupings and alleles are overwritten below
    repeat ($urandom_range(0, 2))
      send_request(MODE_LOAD, $urandom_range(0, 15), $urandom_range(0, 63),
                   $urandom_range(0, 65535), $urandom_range(0, 65535), $urandom_range(0, 127),
                   1'b0);
    for (int p = 0; p < eng; p++) begin
      sz = big ? $urandom_range(0, 65535) : $urandom_range(0, 24);
      for (int i = 0; i < rows; i++) begin
        cnt = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535)
                                           : $urandom_range(0, sz + 3);
        send_request(MODE_LOAD, p, i, cnt, sz, $urandom_range(0, 127),
                     (p == eng - 1) && (i == rows - 1));
      end
    end
    nq = $urandom_range(3, 10);
    for (int k = 0; k < nq; k++) begin
      grp = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(0, eng - 1);
      pick = $urandom_range(0, 9);
      g = (pick < 7) ? $urandom_range(0, big ? egl : 24)
        : (pick < 9) ? $urandom_range(0, 70) : $urandom_range(0, 127);
      query(grp, g);
    end
  endtask

  initial begin
    int ng_val, na_val, gl_val;
    bit big;
    rst <= 1'b1;
    item_ch.valid <= 1'b0;
    item_ch.mode <= MODE_LOAD;
    item_ch.grouping <= '0;
    item_ch.allele <= '0;
    item_ch.allele_count <= '0;
    item_ch.sample_size <= '0;
    item_ch.size_g <= '0;
    item_ch.last <= 1'b0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= CFG_NUM_GROUPINGS;
    cfg_ch.data <= '0;
    requests_sent = 0;
    burst_left = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: query with no table yet
    query(0, 3);
    wait_drained();
    write_register(CFG_NUM_GROUPINGS, 2);
    write_register(CFG_NUM_ALLELES, 2);
    write_register(CFG_G_LIMIT, 64);
    // full-scale counts, zero count, count above sample size
    send_request(MODE_LOAD, 0, 0, 65535, 65535, 0, 1'b0);
    send_request(MODE_LOAD, 0, 1, 0, 65535, 0, 1'b0);
    send_request(MODE_LOAD, 1, 0, 12, 10, 0, 1'b0);
    send_request(MODE_LOAD, 1, 1, 3, 10, 0, 1'b1);
    query(0, 1);
    query(0, 10);
    query(1, 10);
    query(0, 11);   // past smallest sample size
    query(5, 2);    // grouping not loaded
    query(1, 0);    // zero sample size
    query(0, 127);  // past the table
    query(1, 64);

    // register extremes and out-of-range values
    run_locus(16, 1, 64, 1'b1);
    run_locus(1, 64, 2, 1'b0);
    run_locus(0, 0, 0, 1'b0);
    run_locus(31, 3, 1, 1'b0);
    run_locus(1, 100, 127, 1'b1);
    run_locus(48, 1, 65, 1'b0);

    // random loci, mostly small
    while (requests_sent < 580) begin
      ng_val = $urandom_range(1, 4);
      na_val = $urandom_range(1, 6);
      gl_val = $urandom_range(2, 64);
      if ($urandom_range(0, 7) == 0) begin
        ng_val = $urandom_range(0, 127);
        na_val = $urandom_range(0, 2);
        gl_val = $urandom_range(0, 127);
      end
      big = ((ng_val & 31) * na_val <= 8) && ($urandom_range(0, 4) == 0);
      run_locus(ng_val, na_val, gl_val, big);
    end

    wait_drained();
    repeat (20) @(posedge clk);
    $display("Sent %0d requests over %0d table builds; %0d answers checked.",
             requests_sent, builds_seen, answers_checked);
    if (errors == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
`default_nettype wire
